// ----- rtl/rism_pkg.sv -----
// shared types and constants of the row interval set merge block
package rism_pkg;

  // result kinds
  localparam logic [1:0] KIND_MERGED = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INVALID  = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY = 2'd2;

  // most merged results sent for one load
  localparam int unsigned RESULT_CAP = 16;

  // field widths on the channels
  localparam int unsigned ROW_IN_W  = 32;
  localparam int unsigned ROW_OUT_W = 20;

  // commands from controller to datapath
  typedef struct packed {
    logic take;       // latch the incoming transaction
    logic dec_load;   // update the load error flag
    logic q_init;     // open the search window
    logic q_rd;       // read the merged list at the window middle
    logic q_step;     // narrow the window
    logic q_out;      // send the query answer
    logic ins_init;   // insertion hole at the end of the load list
    logic ins_rd;     // read the entry below the hole
    logic ins_shift;  // move that entry up into the hole
    logic ins_put;    // write the new interval into the hole
    logic err_out;    // send the error result, drop the set
    logic mrg_init;   // start the merge walk
    logic mrg_rd;     // read the next sorted load entry
    logic mrg_step;   // fold it into the open merged interval
    logic mrg_put;    // close the last merged interval
    logic emt_rd;     // read the next merged entry for output
    logic emt_out;    // send it
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_query;
    logic fin;
    logic failed;
    logic count_zero;
    logic load_full;
    logic ptr_is_one;
    logic shift_need;
    logic search_open;
    logic mrg_last;
    logic emt_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/rism_if.sv -----
// channel interfaces for load/query transactions and results
interface rism_item_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [rism_pkg::ROW_IN_W-1:0]   range_start;
  logic [rism_pkg::ROW_IN_W-1:0]   range_end;
  logic                            final_interval;
  logic [rism_pkg::ROW_IN_W-1:0]   query_row;

  modport source (output valid, opcode, range_start, range_end, final_interval, query_row,
                  input ready);
  modport sink (input valid, opcode, range_start, range_end, final_interval, query_row,
                output ready);
endinterface

interface rism_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      result_kind;
  logic [rism_pkg::ROW_OUT_W-1:0]  merged_start;
  logic [rism_pkg::ROW_OUT_W-1:0]  merged_end;
  logic                            covered;
  logic [1:0]                      error_code;
  logic                            run_end;

  modport source (output valid, result_kind, merged_start, merged_end, covered, error_code,
                  run_end, input ready);
  modport sink (input valid, result_kind, merged_start, merged_end, covered, error_code,
                run_end, output ready);
endinterface

// ----- rtl/row_interval_set_merge.sv -----
// top level of the row interval set merge block
// usage:
//   item channel: opcode 0 loads one inclusive row interval, final_interval closes
//   the load; opcode 1 asks whether query_row lies in the merged set
//   result channel: one answer per query; per closed load either the merged
//   intervals in start order (at most sixteen) or one error transaction, run_end
//   marking the last transaction caused by an item
// operation:
//   one item at a time; a query runs a binary search over the merged list memory,
//   each probe going through its registered read port; every load is inserted
//   into the start-ordered load list by comparing with and shifting up the
//   entries that start later, and is not stored once the list is full; a
//   closing load then walks the sorted load list to merge it, closes the merged
//   list and sends the merged transactions, or sends one error transaction
// reset: control state clears, the set is empty and no load is open
// stall: a finished transaction waits in the output register; the block stops
//   in the state that produces the next transaction until the slot frees
module row_interval_set_merge #(
  parameter int unsigned      MAX_INTERVALS = 16,
  parameter longint unsigned  ROW_LIMIT     = 1048576
) (
  input  logic            clk,
  input  logic            rst,
  rism_item_if.sink       item,
  rism_result_if.source   result
);

  rism_pkg::cmd_t     cmd;
  rism_pkg::status_t  status;

  // sequencing
  rism_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // storage, compare logic and output register
  rism_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .ROW_LIMIT     (ROW_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (item.opcode),
    .range_start    (item.range_start),
    .range_end      (item.range_end),
    .final_interval (item.final_interval),
    .query_row      (item.query_row),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_kind    (result.result_kind),
    .merged_start   (result.merged_start),
    .merged_end     (result.merged_end),
    .covered        (result.covered),
    .error_code     (result.error_code),
    .run_end        (result.run_end)
  );

  // one transaction in flight: the item side closes right after an accept
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while another is in progress");

  // an error result always ends its run and carries a code
  a_err_shape : assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == rism_pkg::KIND_ERROR) |->
      result.run_end && (result.error_code != rism_pkg::ERR_NONE))
    else $error("malformed error result");

  // query answers are single transactions with no interval payload
  a_query_shape : assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == rism_pkg::KIND_QUERY) |->
      result.run_end && (result.merged_start == '0) && (result.merged_end == '0))
    else $error("malformed query answer");

  // a merged interval never runs backwards
  a_merged_order : assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == rism_pkg::KIND_MERGED) |->
      (result.merged_start <= result.merged_end) || (ROW_LIMIT > 1048576))
    else $error("merged interval with start above end");

endmodule

// ----- rtl/rism_dp.sv -----
// datapath: load list, merged list, search window and output register
module rism_dp #(
  parameter int unsigned      MAX_INTERVALS = 16,
  parameter longint unsigned  ROW_LIMIT     = 1048576
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rism_pkg::cmd_t                  cmd,
  output rism_pkg::status_t               status,
  input  logic                            opcode,
  input  logic [rism_pkg::ROW_IN_W-1:0]   range_start,
  input  logic [rism_pkg::ROW_IN_W-1:0]   range_end,
  input  logic                            final_interval,
  input  logic [rism_pkg::ROW_IN_W-1:0]   query_row,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [1:0]                      result_kind,
  output logic [rism_pkg::ROW_OUT_W-1:0]  merged_start,
  output logic [rism_pkg::ROW_OUT_W-1:0]  merged_end,
  output logic                            covered,
  output logic [1:0]                      error_code,
  output logic                            run_end
);

  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned RowW = $clog2(ROW_LIMIT);
  localparam int unsigned InW  = rism_pkg::ROW_IN_W;
  localparam int unsigned OutW = rism_pkg::ROW_OUT_W;

  typedef struct packed {
    logic [RowW-1:0] s;
    logic [RowW-1:0] e;
  } pair_t;

  // latched transaction
  logic            it_op;
  logic [InW-1:0]  it_s;
  logic [InW-1:0]  it_e;
  logic            it_fin;
  logic [InW-1:0]  it_row;

  // set state
  logic [CntW-1:0] load_count;
  logic [1:0]      load_failed;
  logic [CntW-1:0] merged_count;

  // working registers
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] lo;
  logic [CntW-1:0] hi;
  logic [CntW-1:0] m;
  logic            hit;
  pair_t           cur;

  // memories
  pair_t lmem [MAX_INTERVALS];
  pair_t mmem [MAX_INTERVALS];
  pair_t lrd;
  pair_t mrd;

  logic            invalid;
  pair_t           it_pair;
  logic [CntW-1:0] ptr_m1;
  logic [CntW:0]   ptr_p1;
  logic [CntW:0]   mid_sum;
  logic [CntW-1:0] mid;
  logic [IdxW-1:0] l_ra;
  logic [IdxW-1:0] m_ra;
  logic            l_we;
  pair_t           l_wd;
  logic            m_we;
  logic            joins;
  logic [RowW-1:0] max_e;
  logic            s_le_row;
  logic            row_le_e;

  assign invalid  = (it_s > it_e) || (64'(it_e) >= 64'(ROW_LIMIT));
  assign it_pair  = '{s: it_s[RowW-1:0], e: it_e[RowW-1:0]};
  assign ptr_m1   = ptr - CntW'(1);
  assign ptr_p1   = {1'b0, ptr} + (CntW + 1)'(1);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CntW:1];
  assign l_ra     = cmd.ins_rd ? ptr_m1[IdxW-1:0] : ptr[IdxW-1:0];
  assign m_ra     = cmd.q_rd ? mid[IdxW-1:0] : ptr[IdxW-1:0];
  assign joins    = ({1'b0, lrd.s} <= ({1'b0, cur.e} + (RowW + 1)'(1)));
  assign max_e    = (lrd.e > cur.e) ? lrd.e : cur.e;
  assign s_le_row = (InW'(mrd.s) <= it_row);
  assign row_le_e = (it_row <= InW'(mrd.e));
  assign l_we     = cmd.ins_shift || cmd.ins_put;
  assign l_wd     = cmd.ins_shift ? lrd : it_pair;
  assign m_we     = (cmd.mrg_step && (ptr != '0) && !joins) || cmd.mrg_put;

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[ptr[IdxW-1:0]] <= l_wd;
    end
    if (cmd.ins_rd || cmd.mrg_rd) begin
      lrd <= lmem[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mmem[m[IdxW-1:0]] <= cur;
    end
    if (cmd.q_rd || cmd.emt_rd) begin
      mrd <= mmem[m_ra];
    end
  end

  // transaction latch and working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_op  <= opcode;
      it_s   <= range_start;
      it_e   <= range_end;
      it_fin <= final_interval;
      it_row <= query_row;
    end
    if (cmd.q_init) begin
      lo  <= '0;
      hi  <= merged_count;
      hit <= 1'b0;
    end
    if (cmd.q_step) begin
      if (s_le_row) begin
        lo  <= mid + CntW'(1);
        hit <= row_le_e;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.ins_init) begin
      ptr <= load_count;
    end
    if (cmd.ins_shift) begin
      ptr <= ptr_m1;
    end
    if (cmd.mrg_init) begin
      ptr <= '0;
      m   <= '0;
    end
    if (cmd.mrg_step) begin
      ptr <= ptr_p1[CntW-1:0];
      if (ptr == '0) begin
        cur <= lrd;
      end else if (joins) begin
        cur.e <= max_e;
      end else begin
        m   <= m + CntW'(1);
        cur <= lrd;
      end
    end
    if (cmd.mrg_put) begin
      ptr <= '0;
    end
    if (cmd.emt_out) begin
      ptr <= ptr_p1[CntW-1:0];
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      load_failed  <= rism_pkg::ERR_NONE;
      merged_count <= '0;
    end else begin
      if (cmd.dec_load) begin
        if (invalid) begin
          load_failed <= rism_pkg::ERR_INVALID;
        end else if (status.load_full && (load_failed == rism_pkg::ERR_NONE)) begin
          load_failed <= rism_pkg::ERR_TOO_MANY;
        end
      end
      if (cmd.ins_put) begin
        load_count <= load_count + CntW'(1);
      end
      if (cmd.err_out) begin
        load_count   <= '0;
        load_failed  <= rism_pkg::ERR_NONE;
        merged_count <= '0;
      end
      if (cmd.mrg_put) begin
        load_count   <= '0;
        load_failed  <= rism_pkg::ERR_NONE;
        merged_count <= m + CntW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.q_out || cmd.err_out || cmd.emt_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_out) begin
      result_kind  <= rism_pkg::KIND_QUERY;
      merged_start <= '0;
      merged_end   <= '0;
      covered      <= hit;
      error_code   <= rism_pkg::ERR_NONE;
      run_end      <= 1'b1;
    end else if (cmd.err_out) begin
      result_kind  <= rism_pkg::KIND_ERROR;
      merged_start <= '0;
      merged_end   <= '0;
      covered      <= 1'b0;
      error_code   <= load_failed;
      run_end      <= 1'b1;
    end else if (cmd.emt_out) begin
      result_kind  <= rism_pkg::KIND_MERGED;
      merged_start <= OutW'(mrd.s);
      merged_end   <= OutW'(mrd.e);
      covered      <= 1'b0;
      error_code   <= rism_pkg::ERR_NONE;
      run_end      <= status.emt_last;
    end
  end

  assign status.is_query    = it_op;
  assign status.fin         = it_fin;
  assign status.failed      = (load_failed != rism_pkg::ERR_NONE);
  assign status.count_zero  = (load_count == '0);
  assign status.load_full   = (load_count == CntW'(MAX_INTERVALS));
  assign status.ptr_is_one  = (ptr == CntW'(1));
  assign status.shift_need  = (lrd.s > it_s[RowW-1:0]);
  assign status.search_open = (lo < hi);
  assign status.mrg_last    = (ptr_p1 == {1'b0, load_count});
  assign status.emt_last    = (ptr_p1 == {1'b0, merged_count}) ||
                              (32'(ptr_p1) == rism_pkg::RESULT_CAP);
  assign status.out_free    = !result_valid || result_ready;

endmodule

// ----- rtl/rism_ctrl.sv -----
// controller state machine sequencing queries, inserts, merge and output
module rism_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  rism_pkg::status_t  status,
  output rism_pkg::cmd_t     cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DEC     = 4'd1;
  localparam logic [3:0] ST_Q_RD    = 4'd2;
  localparam logic [3:0] ST_Q_CMP   = 4'd3;
  localparam logic [3:0] ST_Q_OUT   = 4'd4;
  localparam logic [3:0] ST_INS_RD  = 4'd5;
  localparam logic [3:0] ST_INS_CMP = 4'd6;
  localparam logic [3:0] ST_INS_PUT = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;
  localparam logic [3:0] ST_ERR     = 4'd9;
  localparam logic [3:0] ST_MRG_RD  = 4'd10;
  localparam logic [3:0] ST_MRG_CMP = 4'd11;
  localparam logic [3:0] ST_MRG_PUT = 4'd12;
  localparam logic [3:0] ST_EMT_RD  = 4'd13;
  localparam logic [3:0] ST_EMT_OUT = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (status.is_query) begin
          cmd.q_init = 1'b1;
          state_next = ST_Q_RD;
        end else begin
          cmd.dec_load = 1'b1;
          if (status.load_full) begin
            state_next = ST_FIN;
          end else begin
            cmd.ins_init = 1'b1;
            state_next   = status.count_zero ? ST_INS_PUT : ST_INS_RD;
          end
        end
      end
      ST_Q_RD: begin
        if (status.search_open) begin
          cmd.q_rd   = 1'b1;
          state_next = ST_Q_CMP;
        end else begin
          state_next = ST_Q_OUT;
        end
      end
      ST_Q_CMP: begin
        cmd.q_step = 1'b1;
        state_next = ST_Q_RD;
      end
      ST_Q_OUT: begin
        if (status.out_free) begin
          cmd.q_out  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_next = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (status.shift_need) begin
          cmd.ins_shift = 1'b1;
          state_next    = status.ptr_is_one ? ST_INS_PUT : ST_INS_RD;
        end else begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (!status.fin) begin
          state_next = ST_IDLE;
        end else if (status.failed) begin
          state_next = ST_ERR;
        end else begin
          cmd.mrg_init = 1'b1;
          state_next   = ST_MRG_RD;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.err_out = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_MRG_RD: begin
        cmd.mrg_rd = 1'b1;
        state_next = ST_MRG_CMP;
      end
      ST_MRG_CMP: begin
        cmd.mrg_step = 1'b1;
        state_next   = status.mrg_last ? ST_MRG_PUT : ST_MRG_RD;
      end
      ST_MRG_PUT: begin
        cmd.mrg_put = 1'b1;
        state_next  = ST_EMT_RD;
      end
      ST_EMT_RD: begin
        cmd.emt_rd = 1'b1;
        state_next = ST_EMT_OUT;
      end
      ST_EMT_OUT: begin
        if (status.out_free) begin
          cmd.emt_out = 1'b1;
          state_next  = status.emt_last ? ST_IDLE : ST_EMT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/tb_row_interval_set_merge.sv -----
// self-checking testbench for the row interval set merge block
`timescale 1ns / 100ps

module tb_row_interval_set_merge;

  localparam int unsigned     MAX_INTERVALS = 16;
  localparam longint unsigned ROW_LIMIT     = 1048576;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int TOTAL_ITEMS  = 220;
  localparam int IDLE_PCT     = 18;
  localparam int CALM_FROM    = 110;   // no idling on either side in this item window
  localparam int CALM_TO      = 170;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES = 200;
  localparam int REPORT_MAX   = 10;

  // shapes of randomly loaded intervals
  typedef enum int {SHAPE_CLUSTER, SHAPE_SPREAD, SHAPE_WIDE} shape_t;

  typedef struct packed {
    logic                          opcode;
    logic [rism_pkg::ROW_IN_W-1:0] range_start;
    logic [rism_pkg::ROW_IN_W-1:0] range_end;
    logic                          final_interval;
    logic [rism_pkg::ROW_IN_W-1:0] query_row;
  } item_t;

  typedef struct packed {
    logic [1:0]                     kind;
    logic [rism_pkg::ROW_OUT_W-1:0] first_row;
    logic [rism_pkg::ROW_OUT_W-1:0] last_row;
    logic                           covered;
    logic [1:0]                     err;
    logic                           run_end;
  } res_t;

  // one row of the directed table; a zero result means the answer comes from the predictor
  typedef struct packed {
    item_t it;
    res_t  want;
  } dir_row_t;

  localparam res_t PREDICTED    = '0;
  localparam res_t NO_HIT       = {rism_pkg::KIND_QUERY, 20'd0, 20'd0, 1'b0,
                                   rism_pkg::ERR_NONE, 1'b1};
  localparam res_t BAD_INTERVAL = {rism_pkg::KIND_ERROR, 20'd0, 20'd0, 1'b0,
                                   rism_pkg::ERR_INVALID, 1'b1};

  logic clk;
  logic rst;

  rism_item_if   item_ch ();
  rism_result_if result_ch ();

  row_interval_set_merge #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .ROW_LIMIT     (ROW_LIMIT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // predictor state: the open load and the merged row set
  logic [31:0] ld_start [MAX_INTERVALS];
  logic [31:0] ld_end   [MAX_INTERVALS];
  int unsigned ld_count = 0;
  logic [1:0]  ld_err   = rism_pkg::ERR_NONE;
  logic [31:0] set_start [MAX_INTERVALS];
  logic [31:0] set_end   [MAX_INTERVALS];
  int unsigned set_count = 0;

  res_t fresh_results [$];  // what the item just accepted causes
  res_t due_results   [$];  // result transactions still awaited, oldest first

  int mismatches = 0;
  int items_sent = 0;
  bit calm       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic res_t make_res(logic [1:0] kind, logic [31:0] s, logic [31:0] e,
                                    logic cov, logic [1:0] err, logic last);
    res_t r;
    r.kind      = kind;
    r.first_row = s[rism_pkg::ROW_OUT_W-1:0];
    r.last_row  = e[rism_pkg::ROW_OUT_W-1:0];
    r.covered   = cov;
    r.err       = err;
    r.run_end   = last;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic op, logic [31:0] st, logic [31:0] en, logic fin,
                                      logic [31:0] qr, res_t want);
    dir_row_t d;
    d.it.opcode         = op;
    d.it.range_start    = st;
    d.it.range_end      = en;
    d.it.final_interval = fin;
    d.it.query_row      = qr;
    d.want              = want;
    return d;
  endfunction

  // updates the row set for one accepted item and leaves its results in fresh_results
  function automatic void apply_item(input item_t it);
    logic [31:0] s [MAX_INTERVALS];
    logic [31:0] e [MAX_INTERVALS];
    logic [31:0] ks, ke;
    logic        hit;
    int          j, m, n;
    fresh_results.delete();
    if (it.opcode == OP_QUERY) begin
      hit = 1'b0;
      for (int i = 0; i < set_count; i++)
        if (it.query_row >= set_start[i] && it.query_row <= set_end[i]) hit = 1'b1;
      fresh_results = {fresh_results,
                       make_res(rism_pkg::KIND_QUERY, '0, '0, hit, rism_pkg::ERR_NONE, 1'b1)};
      return;
    end
    // an invalid interval wins over an overfull load whatever the order
    if (it.range_start > it.range_end || {32'd0, it.range_end} >= ROW_LIMIT)
      ld_err = rism_pkg::ERR_INVALID;
    if (ld_count < MAX_INTERVALS) begin
      ld_start[ld_count] = it.range_start;
      ld_end[ld_count]   = it.range_end;
      ld_count++;
    end else if (ld_err == rism_pkg::ERR_NONE) begin
      ld_err = rism_pkg::ERR_TOO_MANY;
    end
    if (!it.final_interval) return;
    if (ld_err != rism_pkg::ERR_NONE) begin
      fresh_results = {fresh_results,
                       make_res(rism_pkg::KIND_ERROR, '0, '0, 1'b0, ld_err, 1'b1)};
      set_count = 0;
      ld_count  = 0;
      ld_err    = rism_pkg::ERR_NONE;
      return;
    end
    // stable insertion sort by start
    for (int i = 0; i < ld_count; i++) begin
      ks = ld_start[i];
      ke = ld_end[i];
      j  = i;
      while (j > 0 && s[j-1] > ks) begin
        s[j] = s[j-1];
        e[j] = e[j-1];
        j--;
      end
      s[j] = ks;
      e[j] = ke;
    end
    // fold overlapping or touching intervals
    m = 0;
    for (int i = 0; i < ld_count; i++) begin
      if (m > 0 && {1'b0, s[i]} <= {1'b0, set_end[m-1]} + 33'd1) begin
        if (e[i] > set_end[m-1]) set_end[m-1] = e[i];
      end else begin
        set_start[m] = s[i];
        set_end[m]   = e[i];
        m++;
      end
    end
    set_count = m;
    ld_count  = 0;
    ld_err    = rism_pkg::ERR_NONE;
    n = (set_count > rism_pkg::RESULT_CAP) ? rism_pkg::RESULT_CAP : set_count;
    for (int i = 0; i < n; i++)
      fresh_results = {fresh_results,
                       make_res(rism_pkg::KIND_MERGED, set_start[i], set_end[i], 1'b0,
                                rism_pkg::ERR_NONE, i == n - 1)};
  endfunction

  // presents one item, waits for its transaction and books the expected results
  task automatic drive_item(input item_t it, input res_t want);
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.opcode         <= it.opcode;
    item_ch.range_start    <= it.range_start;
    item_ch.range_end      <= it.range_end;
    item_ch.final_interval <= it.final_interval;
    item_ch.query_row      <= it.query_row;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    // transaction taken at this edge
    apply_item(it);
    if (want != PREDICTED) begin
      due_results = {due_results, want};
    end else begin
      due_results = {due_results, fresh_results};
    end
    items_sent++;
  endtask

  // query rows mostly sit on or next to the edges of merged intervals
  function automatic logic [31:0] pick_row();
    int unsigned pick;
    int unsigned k;
    logic [31:0] base;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom();
    if (pick < 8 && set_count > 0) begin
      k    = $urandom_range(0, set_count - 1);
      base = $urandom_range(0, 1) ? set_start[k] : set_end[k];
      return base + $urandom_range(0, 2) - 1;
    end
    return $urandom_range(0, 32'h0010_0100);
  endfunction

  task automatic send_query();
    item_t it;
    it.opcode         = OP_QUERY;
    it.range_start    = $urandom();
    it.range_end      = $urandom();
    it.final_interval = 1'($urandom_range(0, 1));
    it.query_row      = pick_row();
    drive_item(it, PREDICTED);
  endtask

  // a load of n intervals, the last one final; bad_at picks one invalid interval, -1 for none
  task automatic send_load(input int n, input shape_t shape, input int bad_at);
    item_t       it;
    int unsigned slot [16];
    int unsigned k, tmp;
    logic [31:0] st, en;
    // spread intervals sit in 64k slots, distinct for the first sixteen, taken in shuffled order
    for (int i = 0; i < 16; i++) slot[i] = i;
    for (int i = 15; i > 0; i--) begin
      k       = $urandom_range(0, i);
      tmp     = slot[i];
      slot[i] = slot[k];
      slot[k] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      // queries in the middle of a load see the previous set
      if ($urandom_range(0, 99) < 12) send_query();
      case (shape)
        SHAPE_CLUSTER: begin
          st = $urandom_range(0, 400);
          en = st + $urandom_range(0, 60);
        end
        SHAPE_SPREAD: begin
          st = slot[i % 16] * 32'h0001_0000 + $urandom_range(0, 30000);
          en = st + $urandom_range(0, 30000);
        end
        default: begin
          st = $urandom_range(0, 32'(ROW_LIMIT - 1));
          en = $urandom_range(st, 32'(ROW_LIMIT - 1));
        end
      endcase
      if (i == bad_at) begin
        if ($urandom_range(0, 1)) begin
          en = $urandom_range(0, 32'hFFFF_FFFE);
          st = $urandom_range(en + 1, 32'hFFFF_FFFF);
        end else begin
          en = $urandom_range(32'(ROW_LIMIT), 32'hFFFF_FFFF);
          st = $urandom();
        end
      end
      it.opcode         = OP_LOAD;
      it.range_start    = st;
      it.range_end      = en;
      it.final_interval = (i == n - 1);
      it.query_row      = $urandom();
      drive_item(it, PREDICTED);
    end
  endtask

  // result side: ready drops at random outside the calm window
  initial begin : result_pacing
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // each result transaction against the oldest awaited one
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind      = result_ch.result_kind;
      got.first_row = result_ch.merged_start;
      got.last_row  = result_ch.merged_end;
      got.covered   = result_ch.covered;
      got.err       = result_ch.error_code;
      got.run_end   = result_ch.run_end;
      if (due_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result transaction with none awaited: kind=%0d start=%h end=%h",
                   $realtime, got.kind, got.first_row, got.last_row);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.first_row !== want.first_row ||
            got.last_row !== want.last_row || got.covered !== want.covered ||
            got.err !== want.err || got.run_end !== want.run_end) begin
          if (mismatches < REPORT_MAX)
            $display({"%0t: mismatch, expected kind=%0d start=%h end=%h cov=%b err=%0d last=%b,",
                      " got kind=%0d start=%h end=%h cov=%b err=%0d last=%b"},
                     $realtime, want.kind, want.first_row, want.last_row, want.covered,
                     want.err, want.run_end, got.kind, got.first_row, got.last_row,
                     got.covered, got.err, got.run_end);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no transaction on either channel ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows [$];
    int       pick;
    int       len;
    rst                    <= 1'b1;
    item_ch.valid          <= 1'b0;
    item_ch.opcode         <= OP_LOAD;
    item_ch.range_start    <= '0;
    item_ch.range_end      <= '0;
    item_ch.final_interval <= 1'b0;
    item_ch.query_row      <= '0;

    // directed table
    //                   op        range_start   range_end     fin   query_row     expected
    // empty set straight after reset
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h0,        NO_HIT)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'hFFFF_FFFF, NO_HIT)};
    // a single-row interval, an overlap, a touching pair and the top row
    rows = {rows, mk_row(OP_LOAD,  32'h0,        32'h0,        1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'd10,       32'd20,       1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'd21,       32'd30,       1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'd5,        32'd12,       1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'h000F_FFFF, 32'h000F_FFFF, 1'b1, 32'h0,      PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b1, 32'd31,       PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h000F_FFFF, PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h0010_0000, PREDICTED)};
    // start above end, then the set is gone
    rows = {rows, mk_row(OP_LOAD,  32'd5,        32'd4,        1'b1, 32'h0,        BAD_INTERVAL)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h0,        NO_HIT)};
    // end at the row limit and at the top of the field
    rows = {rows, mk_row(OP_LOAD,  32'h0,        32'h0010_0000, 1'b1, 32'h0,       BAD_INTERVAL)};
    rows = {rows, mk_row(OP_LOAD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,      BAD_INTERVAL)};
    // whole row range as one interval
    rows = {rows, mk_row(OP_LOAD,  32'h0,        32'h000F_FFFF, 1'b1, 32'h0,       PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'h0008_0000, PREDICTED)};
    // query while a load is open, then a contained interval
    rows = {rows, mk_row(OP_LOAD,  32'd100,      32'd200,      1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'd50,       PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'd150,      32'd300,      1'b0, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_LOAD,  32'd202,      32'd210,      1'b1, 32'h0,        PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'd301,      PREDICTED)};
    rows = {rows, mk_row(OP_QUERY, 32'h0,        32'h0,        1'b0, 32'd100,      PREDICTED)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) drive_item(rows[r].it, rows[r].want);

    // sure hits on the long cases: a full list of sixteen, overfull loads with and
    // without an invalid interval beyond the capacity
    send_load(16, SHAPE_SPREAD, -1);
    send_query();
    send_load(17, SHAPE_CLUSTER, -1);
    send_load(18, SHAPE_WIDE, 17);

    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 4)) send_query();
      end else if (pick < 80) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 16);
        send_load(len, shape_t'($urandom_range(0, 2)), -1);
      end else if (pick < 88) begin
        send_load(16, SHAPE_SPREAD, -1);
      end else if (pick < 94) begin
        len = $urandom_range(17, 20);
        send_load(len, shape_t'($urandom_range(0, 2)),
                  $urandom_range(0, 1) ? -1 : int'($urandom_range(0, len - 1)));
      end else begin
        len = $urandom_range(1, 6);
        send_load(len, shape_t'($urandom_range(0, 2)), int'($urandom_range(0, len - 1)));
      end
    end
    item_ch.valid <= 1'b0;

    // drain, then give a trailing load time to show any stray transaction
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
